// File: rtl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgDebounceDelay = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongThresh    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgExtraThresh   = 2'd2;

  // Register widths and reset values
  localparam int unsigned DelayW  = 8;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned StableW = 9;

  localparam logic [DelayW-1:0]  DelayRst       = 8'd50;
  localparam logic [ThreshW-1:0] LongThreshRst  = 16'd1000;
  localparam logic [ThreshW-1:0] ExtraThreshRst = 16'd3000;
  localparam logic [StableW-1:0] StableMax      = 9'd511;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic extra_ev;
  } events_t;

  typedef struct packed {
    logic debounced;
    logic long_done;
    logic extra_done;
  } flags_t;

endpackage

// File: rtl/bdpc_step.sv
`timescale 1ns / 1ps

// Next-state and event logic for one tick.
module bdpc_step #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  logic                           level_i,
  input  logic                           last_raw_i,
  input  logic [bdpc_pkg::StableW-1:0]   stable_i,
  input  logic [HOLD_WIDTH-1:0]          hold_i,
  input  bdpc_pkg::flags_t               flags_i,
  input  logic [bdpc_pkg::DelayW-1:0]    delay_i,
  input  logic [bdpc_pkg::ThreshW-1:0]   long_thr_i,
  input  logic [bdpc_pkg::ThreshW-1:0]   extra_thr_i,
  output logic [bdpc_pkg::StableW-1:0]   stable_o,
  output logic [HOLD_WIDTH-1:0]          hold_o,
  output bdpc_pkg::flags_t               flags_o,
  output bdpc_pkg::events_t              events_o
);

  localparam int unsigned CmpW =
    (HOLD_WIDTH > bdpc_pkg::ThreshW) ? HOLD_WIDTH : bdpc_pkg::ThreshW;

  logic [HOLD_WIDTH-1:0]        hold_inc;
  logic [CmpW-1:0]              hold_inc_c;
  logic [CmpW-1:0]              hold_c;
  logic [CmpW-1:0]              long_c;
  logic [CmpW-1:0]              extra_c;
  logic                         stable_ok;
  logic                         press;

  assign hold_inc = (flags_i.debounced && (hold_i != {HOLD_WIDTH{1'b1}}))
                    ? hold_i + HOLD_WIDTH'(1) : hold_i;

  assign stable_o = (level_i != last_raw_i) ? '0 :
                    (stable_i != bdpc_pkg::StableMax) ? stable_i + bdpc_pkg::StableW'(1) :
                    stable_i;

  assign stable_ok  = stable_o > {1'b0, delay_i};
  // a debounced press restarts the hold timer
  assign press      = stable_ok && level_i && !flags_i.debounced;
  assign hold_o     = press ? '0 : hold_inc;
  assign hold_inc_c = CmpW'(hold_inc);
  assign hold_c     = CmpW'(hold_o);
  assign long_c     = CmpW'(long_thr_i);
  assign extra_c    = CmpW'(extra_thr_i);

  always_comb begin
    flags_o  = flags_i;
    events_o = '0;
    if (stable_ok) begin
      if (level_i != flags_i.debounced) begin
        flags_o.debounced = level_i;
        // either edge clears the handled marks
        flags_o.long_done  = 1'b0;
        flags_o.extra_done = 1'b0;
        if (!level_i) begin
          // release: classify with the old marks
          if (!flags_i.extra_done && (hold_inc_c >= extra_c)) begin
            events_o.extra_ev = 1'b1;
          end else if (!flags_i.long_done && (hold_inc_c >= long_c)) begin
            events_o.long_ev = 1'b1;
          end else if (hold_inc_c < long_c) begin
            events_o.short_ev = 1'b1;
          end
        end
      end
      if (flags_o.debounced) begin
        if ((hold_c >= extra_c) && !flags_o.extra_done) begin
          events_o.extra_ev  = 1'b1;
          flags_o.extra_done = 1'b1;
        end else if ((hold_c >= long_c) && !flags_o.long_done) begin
          events_o.long_ev  = 1'b1;
          flags_o.long_done = 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/button_debounce_press_classifier.sv
`timescale 1ns / 1ps

// An accepted tick beat passes through the input register, then the result register.
// Throughput: one tick beat per cycle unless the sink stalls; the input and result
// registers let the next beat enter while a finished result waits for the sink.
// Reset (rst_ni low, asynchronous): both stages empty, debounce/press state cleared,
// registers back to debounce_delay 50, long_threshold 1000, extra_long_threshold 3000.
module button_debounce_press_classifier #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bdpc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // tick input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            pin_sample_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            pressed_level_o,
  output logic                            short_event_o,
  output logic                            long_event_o,
  output logic                            extra_long_event_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bdpc_pkg::DelayW-1:0]  delay_q;
  logic [bdpc_pkg::ThreshW-1:0] long_thr_q;
  logic [bdpc_pkg::ThreshW-1:0] extra_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= bdpc_pkg::DelayRst;
      long_thr_q  <= bdpc_pkg::LongThreshRst;
      extra_thr_q <= bdpc_pkg::ExtraThreshRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bdpc_pkg::CfgDebounceDelay: delay_q     <= cfg_wdata_i[bdpc_pkg::DelayW-1:0];
        bdpc_pkg::CfgLongThresh:    long_thr_q  <= cfg_wdata_i;
        bdpc_pkg::CfgExtraThresh:   extra_thr_q <= cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: input register -> result register
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_pin_q;
  logic out_valid_q;
  logic out_free;
  logic s1_free;
  logic adv;      // stage-1 beat moves into the result register
  logic in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pin_q <= pin_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Debounce / press state, updated once per tick as it leaves stage 1
  // ---------------------------------------------------------------------------
  logic                           last_raw_q;
  logic [bdpc_pkg::StableW-1:0]   stable_q, stable_d;
  logic [HOLD_WIDTH-1:0]          hold_q, hold_d;
  bdpc_pkg::flags_t               flags_q, flags_d;
  bdpc_pkg::events_t              events_d, events_q;
  logic                           level;

  // pin is active low
  assign level = ~s1_pin_q;

  bdpc_step #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_step (
    .level_i     (level),
    .last_raw_i  (last_raw_q),
    .stable_i    (stable_q),
    .hold_i      (hold_q),
    .flags_i     (flags_q),
    .delay_i     (delay_q),
    .long_thr_i  (long_thr_q),
    .extra_thr_i (extra_thr_q),
    .stable_o    (stable_d),
    .hold_o      (hold_d),
    .flags_o     (flags_d),
    .events_o    (events_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= '0;
      hold_q     <= '0;
      flags_q    <= '0;
    end else if (adv) begin
      last_raw_q <= level;
      stable_q   <= stable_d;
      hold_q     <= hold_d;
      flags_q    <= flags_d;
    end
  end

  // result register
  logic pressed_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pressed_q <= flags_d.debounced;
      events_q  <= events_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pressed_level_o    = pressed_q;
  assign short_event_o      = events_q.short_ev;
  assign long_event_o       = events_q.long_ev;
  assign extra_long_event_o = events_q.extra_ev;

endmodule
